@@ rtl/mlp_forward_mse_macros.svh @@
// Assertion macros for the MLP forward/MSE block.
// Included by the top level; no other dependencies.
`ifndef MLP_FORWARD_MSE_MACROS_SVH
`define MLP_FORWARD_MSE_MACROS_SVH
`define MFM_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("mlp_forward_mse: check failed");
`define MFM_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("mlp_forward_mse: check failed");
`endif

@@ rtl/mfm_pkg.sv @@
// Shared types and constants for the MLP forward/MSE block.
// No dependencies.
package mfm_pkg;
  localparam int MAX_INPUTS_D  = 16;
  localparam int MAX_HIDDEN_D  = 16;
  localparam int MAX_OUTPUTS_D = 8;
  localparam int FRAC_BITS_D   = 8;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FEATURE = 2'd1,
    CMD_EXPECT = 2'd2,
    CMD_END = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

  localparam logic [30:0] SQ_CAP = 31'h4000_0000;
endpackage

@@ rtl/mfm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mfm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/mfm_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module mfm_div #(
  parameter int NW = 48,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] quo_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;

  assign trial = {rem_r[DW-1:0], quo_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= trial - {1'b0, den_r};
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

@@ rtl/mlp_forward_mse.sv @@
// Channel   | ports                                      | direction
// input     | in_valid/in_ready, in_command..in_last      | in
// result    | out_valid/out_ready, out_result_kind..      | out
// config    | cfg_psel..cfg_prdata (APB-style)           | in/out
// Write and feature without last: accepted back to back; the block stays idle.
// Feature with last: forward pass, hidden layer then output layer, on one shared MAC
//   that reads one weight per S_RD, S_MUL, S_ACC step, then S_BRD, S_BIAS, S_STORE.
// Expected output: S_EXP_RD, S_EXP_SQ, S_EXP_SUM, then the result from S_FIN; the last one
//   passes through S_DIV (divider) first; end of set: S_END, S_DIV, then S_FIN.
// Reset: synchronous, clears sums and control; memories are undefined.
// in_ready drops while an item is in work; a waiting result holds only the next result.
`include "mlp_forward_mse_macros.svh"
module mlp_forward_mse import mfm_pkg::*; #(
  parameter int MAX_INPUTS  = MAX_INPUTS_D,
  parameter int MAX_HIDDEN  = MAX_HIDDEN_D,
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_D,
  parameter int FRAC_BITS   = FRAC_BITS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [8:0]  in_index,
  input  logic signed [15:0] in_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [2:0]  out_output_index,
  output logic signed [15:0] out_output_value,
  output logic [30:0] out_squared_error,
  output logic [30:0] out_sample_error,
  output logic signed [30:0] out_fitness,
  output logic        out_sample_done,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int DEPTH = MAX_INPUTS*MAX_HIDDEN + MAX_HIDDEN*MAX_OUTPUTS
                         + MAX_HIDDEN + MAX_OUTPUTS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int AH = (MAX_HIDDEN > 1) ? MAX_HIDDEN : 2;
  localparam int AO = (MAX_OUTPUTS > 1) ? MAX_OUTPUTS : 2;
  localparam int AI = (MAX_INPUTS > 1) ? MAX_INPUTS : 2;
  localparam int ACCW = 48;

  // configuration
  logic [4:0] icnt_r, hcnt_r;
  logic [3:0] ocnt_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icnt_r <= 5'd1;
      hcnt_r <= 5'd1;
      ocnt_r <= 4'd1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_INPUT_COUNT:  icnt_r <= cfg_pwdata[4:0];
        REG_HIDDEN_COUNT: hcnt_r <= cfg_pwdata[4:0];
        REG_OUTPUT_COUNT: ocnt_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      REG_INPUT_COUNT:  cfg_prdata = {27'd0, icnt_r};
      REG_HIDDEN_COUNT: cfg_prdata = {27'd0, hcnt_r};
      REG_OUTPUT_COUNT: cfg_prdata = {28'd0, ocnt_r};
      default:          cfg_prdata = '0;
    endcase
  end

  logic [6:0] ni, nh, no;
  always_comb begin
    ni = (icnt_r == 0) ? 7'd1 : (32'(icnt_r) > MAX_INPUTS) ? 7'(MAX_INPUTS) : 7'(icnt_r);
    nh = (hcnt_r == 0) ? 7'd1 : (32'(hcnt_r) > MAX_HIDDEN) ? 7'(MAX_HIDDEN) : 7'(hcnt_r);
    no = (ocnt_r == 0) ? 7'd1 : (32'(ocnt_r) > MAX_OUTPUTS) ? 7'(MAX_OUTPUTS) : 7'(ocnt_r);
  end
  logic [12:0] ho_base, hb_base, ob_base;
  assign ho_base = 13'(ni * nh);
  assign hb_base = ho_base + 13'(nh * no);
  assign ob_base = hb_base + 13'(nh);

  // memories
  logic          pw_we, fw_we, hw_we, ow_we;
  logic [AW-1:0] p_wa, p_ra;
  logic [IW-1:0] f_wa, f_ra;
  logic [HW-1:0] h_wa, h_ra;
  logic [OW-1:0] o_wa, o_ra;
  logic [15:0]   p_wd, f_wd, h_wd, o_wd, p_rd, f_rd, h_rd, o_rd;

  mfm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_par (
    .clk(clk), .we(pw_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  mfm_ram #(.WIDTH(16), .DEPTH(AI)) u_feat (
    .clk(clk), .we(fw_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  mfm_ram #(.WIDTH(16), .DEPTH(AH)) u_hid (
    .clk(clk), .we(hw_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  mfm_ram #(.WIDTH(16), .DEPTH(AO)) u_outv (
    .clk(clk), .we(ow_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  // divider
  logic          dv_start, dv_done;
  logic [47:0]   dv_num, dv_quo;
  logic [15:0]   dv_den;
  mfm_div #(.NW(48), .DW(16)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo));

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_BRD, S_BIAS, S_STORE,
    S_EXP_RD, S_EXP_SQ, S_EXP_SUM, S_END, S_DIV, S_FIN
  } state_t;

  state_t        st_r;
  logic          layer_r;        // 0 hidden, 1 output
  logic [6:0]    nrn_r, k_r;
  logic [ACCW-1:0] acc_r;
  logic signed [31:0] prod_r;
  logic [8:0]    idx_r;
  logic signed [15:0] val_r;
  logic          last_r, cmd3_r;
  logic [33:0]   ssum_r;
  logic [47:0]   dsum_r;
  logic [15:0]   scnt_r;
  logic [30:0]   sq_r;
  logic [15:0]   rdv_r;
  logic          ov_r;
  logic          o_kind_r, o_done_r;
  logic [2:0]    o_idx_r;
  logic signed [15:0] o_val_r;
  logic [30:0]   o_sq_r, o_se_r, o_fit_r;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_result_kind = o_kind_r;
  assign out_output_index = o_idx_r;
  assign out_output_value = o_val_r;
  assign out_squared_error = o_sq_r;
  assign out_sample_error = o_se_r;
  assign out_fitness = o_fit_r;
  assign out_sample_done = o_done_r;

  logic acc_in;
  assign acc_in = in_valid && in_ready;

  logic fin_fire;
  assign fin_fire = (st_r == S_FIN) && (!ov_r || out_ready);

  logic [15:0] act_rd;
  assign act_rd = layer_r ? h_rd : f_rd;

  // address of current weight (activation is read at k_r)
  logic [12:0] w_addr;
  always_comb begin
    if (!layer_r) w_addr = 13'(nrn_r * ni) + 13'(k_r);
    else          w_addr = ho_base + 13'(nrn_r * nh) + 13'(k_r);
  end

  // scale and saturate
  logic signed [ACCW-1:0] shf;
  logic signed [15:0]     sat;
  always_comb begin
    shf = $signed(acc_r) >>> FRAC_BITS;
    if (shf > 48'sd32767) sat = 16'sh7FFF;
    else if (shf < -48'sd32768) sat = 16'sh8000;
    else sat = shf[15:0];
  end

  logic signed [16:0] diff;
  logic [16:0] mag;
  logic [33:0] sq_full;
  logic [34:0] ssum_add;
  logic [33:0] ssum_new;
  assign diff = 17'(val_r) - 17'($signed(o_rd));
  assign mag  = diff[16] ? 17'(-diff) : 17'(diff);
  assign sq_full = 34'(mag) * 34'(mag);
  assign ssum_add = {1'b0, ssum_r} + {4'd0, sq_r};
  assign ssum_new = ssum_add[34] ? '1 : ssum_add[33:0];

  always_comb begin
    pw_we = acc_in && (in_command == CMD_WRITE) && (32'(in_index) < DEPTH);
    p_wa  = AW'(in_index);
    p_wd  = in_value;
    fw_we = acc_in && (in_command == CMD_FEATURE) && (32'(in_index) < MAX_INPUTS);
    f_wa  = IW'(in_index);
    f_wd  = in_value;
    hw_we = (st_r == S_STORE) && !layer_r;
    h_wa  = HW'(nrn_r);
    h_wd  = sat[15] ? 16'd0 : sat;
    ow_we = (st_r == S_STORE) && layer_r;
    o_wa  = OW'(nrn_r);
    o_wd  = sat;
    p_ra  = (st_r == S_BRD)
            ? AW'((layer_r ? ob_base : hb_base) + 13'(nrn_r)) : AW'(w_addr);
    f_ra  = IW'(k_r);
    h_ra  = HW'(k_r);
    o_ra  = OW'(idx_r);
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = 16'd1;
    if (st_r == S_EXP_SUM && last_r) begin
      dv_start = 1'b1;
      dv_num = {14'd0, ssum_new};
      dv_den = {9'd0, no};
    end else if (st_r == S_END) begin
      dv_start = 1'b1;
      dv_num = dsum_r;
      dv_den = (scnt_r == 0) ? 16'd1 : scnt_r;
    end
  end

  logic [47:0] mean_c;
  logic [47:0] neg_mean;
  logic [48:0] dsum_add;
  always_comb begin
    mean_c = (cmd3_r && scnt_r == 0) ? 48'd0 : dv_quo;
    if (mean_c > 48'(SQ_CAP)) mean_c = 48'(SQ_CAP);
    neg_mean = 48'd0 - mean_c;
    dsum_add = {1'b0, dsum_r} + {1'b0, mean_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ov_r   <= 1'b0;
      ssum_r <= '0;
      dsum_r <= '0;
      scnt_r <= '0;
      cmd3_r <= 1'b0;
      layer_r <= 1'b0;
    end else begin
      ov_r <= fin_fire || (ov_r && !out_ready);
      case (st_r)
        S_IDLE: begin
          if (acc_in) begin
            idx_r  <= in_index;
            val_r  <= in_value;
            last_r <= in_last;
            cmd3_r <= 1'b0;
            case (in_command)
              CMD_FEATURE: begin
                if (in_last) begin
                  layer_r <= 1'b0;
                  nrn_r <= '0;
                  k_r <= '0;
                  acc_r <= '0;
                  st_r <= S_RD;
                end
              end
              CMD_EXPECT: begin
                if (32'(in_index) < MAX_OUTPUTS) st_r <= S_EXP_RD;
              end
              CMD_END: begin
                cmd3_r <= 1'b1;
                st_r <= S_END;
              end
              default: ;
            endcase
          end
        end
        S_RD: st_r <= S_MUL;
        S_MUL: begin
          prod_r <= $signed(p_rd) * $signed(act_rd);
          st_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_r + ACCW'(prod_r);
          k_r <= k_r + 1'b1;
          st_r <= (k_r + 1'b1 == (layer_r ? nh : ni)) ? S_BRD : S_RD;
        end
        S_BRD: st_r <= S_BIAS;
        S_BIAS: begin
          acc_r <= acc_r + (ACCW'($signed(p_rd)) <<< FRAC_BITS);
          st_r <= S_STORE;
        end
        S_STORE: begin
          k_r <= '0;
          acc_r <= '0;
          if (nrn_r + 1'b1 == (layer_r ? no : nh)) begin
            nrn_r <= '0;
            if (layer_r) st_r <= S_IDLE;
            else begin
              layer_r <= 1'b1;
              st_r <= S_RD;
            end
          end else begin
            nrn_r <= nrn_r + 1'b1;
            st_r <= S_RD;
          end
        end
        S_EXP_RD: st_r <= S_EXP_SQ;
        S_EXP_SQ: begin
          sq_r <= (sq_full > 34'(SQ_CAP)) ? SQ_CAP : sq_full[30:0];
          rdv_r <= o_rd;
          st_r <= S_EXP_SUM;
        end
        S_EXP_SUM: begin
          ssum_r <= ssum_new;
          st_r <= last_r ? S_DIV : S_FIN;
        end
        S_END: st_r <= S_DIV;
        S_DIV: begin
          if (dv_done) st_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_fire) begin
            st_r <= S_IDLE;
            o_idx_r <= cmd3_r ? 3'd0 : idx_r[2:0];
            if (cmd3_r) begin
              ssum_r <= '0; dsum_r <= '0; scnt_r <= '0;
              o_kind_r <= 1'b1; o_val_r <= '0; o_sq_r <= '0; o_se_r <= '0;
              o_fit_r <= neg_mean[30:0]; o_done_r <= 1'b0;
            end else begin
              o_kind_r <= 1'b0; o_val_r <= rdv_r; o_sq_r <= sq_r;
              o_fit_r <= '0; o_done_r <= last_r;
              if (last_r) begin
                ssum_r <= '0;
                dsum_r <= dsum_add[48] ? '1 : dsum_add[47:0];
                if (scnt_r != 16'hFFFF) scnt_r <= scnt_r + 1'b1;
                o_se_r <= mean_c[30:0];
              end else begin
                o_se_r <= '0;
              end
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `MFM_ASSERT_IMPL(a_no_accept_busy, acc_in, st_r == S_IDLE)
  `MFM_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid)
  `MFM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_squared_error))
endmodule
